// ----- design/assert_macros.svh -----
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is ignored while reset is high.
`define ASSERT_CLK_DIS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("port check failed");

// Clocked property that is also checked while reset is high.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("port check failed");

`endif

// ----- design/scbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scbc_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int SPAN_WIDTH      = COORD_WIDTH + 1;
  localparam int END_WIDTH       = COORD_WIDTH + 2;
  localparam int COLOR_WIDTH     = 64;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int COUNT_WIDTH     = 17;
  localparam int OUT_QUEUE_DEPTH = 8;

  localparam logic [COUNT_WIDTH-1:0] SEEN_MAX       = '1;
  localparam logic [CFG_WIDTH-1:0]   CAPACITY_RESET = 16'd1024;
  localparam logic [CFG_WIDTH-1:0]   LIMIT_RESET    = 16'd1024;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_BLOCK_CAPACITY = 1'b0,
    REG_INPUT_LIMIT    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] first_row;
    logic [COORD_WIDTH-1:0] row_len;
    logic [COORD_WIDTH-1:0] first_col;
    logic [COORD_WIDTH-1:0] col_len;
    logic [COLOR_WIDTH-1:0] red_bits;
    logic [COLOR_WIDTH-1:0] green_bits;
    logic [COLOR_WIDTH-1:0] blue_bits;
    logic                   end_of_list;
  } rect_t;

  typedef struct packed {
    logic                   has_block;
    logic [COORD_WIDTH-1:0] out_row_start;
    logic [SPAN_WIDTH-1:0]  out_row_count;
    logic [COORD_WIDTH-1:0] out_col_start;
    logic [SPAN_WIDTH-1:0]  out_col_count;
    logic [COLOR_WIDTH-1:0] out_red;
    logic [COLOR_WIDTH-1:0] out_green;
    logic [COLOR_WIDTH-1:0] out_blue;
    logic                   list_status;
    logic                   final_result;
  } result_t;

  // Up to two results per rectangle; second_valid implies first_valid.
  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } scbc_push_t;

endpackage

`default_nettype wire

// ----- design/same_color_block_coalescer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Coalesces a stream of colored rectangles, holding one pending rectangle that
// grows by same-color merges along columns first, then rows. A rectangle is
// registered when taken and processed in the next cycle against the pending
// register; its zero, one or two results enter an OUT_DEPTH-entry result queue
// and are registered there before they can be taken. With the sink always
// ready, one rectangle is taken every cycle as long as each yields at most one
// result; the queue drains one result per cycle, which sets the rate when
// rectangles yield two results, and rect_ready drops once the queue cannot
// hold the results of the rectangle in flight plus one more. Configuration
// writes take effect at the next clock edge.
module same_color_block_coalescer_unit import scbc_pkg::*; #(
  parameter int OUT_DEPTH = OUT_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rect_valid,
  output logic                       rect_ready,
  input  rect_t                      rect,
  output logic                       result_valid,
  input  logic                       result_ready,
  output result_t                    result,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data
);

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic                 s1_valid;
  rect_t                s1_item;
  logic [CFG_WIDTH-1:0] block_capacity;
  logic [CFG_WIDTH-1:0] input_limit;
  scbc_push_t           push;
  logic [CNT_W-1:0]     queue_count;
  logic [CNT_W:0]       reserved;
  logic                 rect_fire;

  // Each rectangle may need two queue entries: one in flight, one arriving.
  assign reserved   = (CNT_W + 1)'(queue_count) + (s1_valid ? (CNT_W + 1)'(2) : '0);
  assign rect_ready = (reserved <= (CNT_W + 1)'(OUT_DEPTH - 2));
  assign rect_fire  = rect_valid && rect_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      block_capacity <= CAPACITY_RESET;
      input_limit    <= LIMIT_RESET;
    end else begin
      s1_valid <= rect_fire;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_BLOCK_CAPACITY: block_capacity <= cfg_data;
          REG_INPUT_LIMIT:    input_limit    <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rect_fire) begin
      s1_item <= rect;
    end
  end

  scbc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (s1_valid),
    .item           (s1_item),
    .block_capacity (block_capacity),
    .input_limit    (input_limit),
    .push           (push)
  );

  scbc_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (result_ready),
    .head_valid (result_valid),
    .head       (result),
    .count      (queue_count)
  );

endmodule

`default_nettype wire

// ----- design/scbc_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scbc_out_fifo import scbc_pkg::*; #(
  parameter int DEPTH = OUT_QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  scbc_push_t       push,
  input  logic             pop,
  output logic             head_valid,
  output result_t          head,
  output logic [CNT_W-1:0] count
);

  result_t          slots [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_plus1;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [CNT_W-1:0] count_next;
  logic             pop_fire;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign head_valid   = (count != '0);
  assign head         = slots[rd_ptr];
  assign pop_fire     = pop && head_valid;
  assign wr_ptr_plus1 = wrap_inc(wr_ptr);

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (push.second_valid) begin
      wr_ptr_next = wrap_inc(wr_ptr_plus1);
    end else if (push.first_valid) begin
      wr_ptr_next = wr_ptr_plus1;
    end
    count_next = count + CNT_W'(push.first_valid) + CNT_W'(push.second_valid)
                 - CNT_W'(pop_fire);
  end

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      slots[wr_ptr_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop_fire) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/scbc_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scbc_core import scbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  rect_t                item,
  input  logic [CFG_WIDTH-1:0] block_capacity,
  input  logic [CFG_WIDTH-1:0] input_limit,
  output scbc_push_t           push
);

  logic                   pend_valid;
  logic                   overflowed;
  logic [COUNT_WIDTH-1:0] kept_count;
  logic [COUNT_WIDTH-1:0] seen_count;
  logic [COORD_WIDTH-1:0] pend_row_start;
  logic [COORD_WIDTH-1:0] pend_col_start;
  logic [SPAN_WIDTH-1:0]  pend_row_count;
  logic [SPAN_WIDTH-1:0]  pend_col_count;
  logic [COLOR_WIDTH-1:0] pend_red;
  logic [COLOR_WIDTH-1:0] pend_green;
  logic [COLOR_WIDTH-1:0] pend_blue;

  logic                   pend_valid_next;
  logic                   overflowed_next;
  logic [COUNT_WIDTH-1:0] kept_count_next;
  logic [COUNT_WIDTH-1:0] seen_count_next;
  logic [COORD_WIDTH-1:0] pend_row_start_next;
  logic [COORD_WIDTH-1:0] pend_col_start_next;
  logic [SPAN_WIDTH-1:0]  pend_row_count_next;
  logic [SPAN_WIDTH-1:0]  pend_col_count_next;
  logic [COLOR_WIDTH-1:0] pend_red_next;
  logic [COLOR_WIDTH-1:0] pend_green_next;
  logic [COLOR_WIDTH-1:0] pend_blue_next;

  logic [END_WIDTH-1:0]   pend_row_end;
  logic [END_WIDTH-1:0]   pend_col_end;
  logic [END_WIDTH-1:0]   in_row_end;
  logic [END_WIDTH-1:0]   in_col_end;
  logic [COORD_WIDTH-1:0] row_lo;
  logic [COORD_WIDTH-1:0] col_lo;
  logic [END_WIDTH-1:0]   row_hi;
  logic [END_WIDTH-1:0]   col_hi;
  logic                   nonempty;
  logic                   color_match;
  logic                   col_fits;
  logic                   row_fits;
  logic [COUNT_WIDTH-1:0] seen_inc;
  result_t                emitted;

  // The pending ends stay below 2^(COORD_WIDTH+1), so END_WIDTH never wraps.
  assign pend_row_end = END_WIDTH'(pend_row_start) + END_WIDTH'(pend_row_count);
  assign pend_col_end = END_WIDTH'(pend_col_start) + END_WIDTH'(pend_col_count);
  assign in_row_end   = END_WIDTH'(item.first_row) + END_WIDTH'(item.row_len);
  assign in_col_end   = END_WIDTH'(item.first_col) + END_WIDTH'(item.col_len);

  assign row_lo = (pend_row_start < item.first_row) ? pend_row_start : item.first_row;
  assign col_lo = (pend_col_start < item.first_col) ? pend_col_start : item.first_col;
  assign row_hi = (pend_row_end > in_row_end) ? pend_row_end : in_row_end;
  assign col_hi = (pend_col_end > in_col_end) ? pend_col_end : in_col_end;

  assign nonempty    = (item.row_len != '0) && (item.col_len != '0);
  assign color_match = pend_valid && (pend_red == item.red_bits) &&
                       (pend_green == item.green_bits) && (pend_blue == item.blue_bits);

  // Touching ranges count as mergeable, hence the non-strict compares.
  assign col_fits = (pend_row_start == item.first_row) &&
                    (pend_row_count == SPAN_WIDTH'(item.row_len)) &&
                    !(END_WIDTH'(item.first_col) > pend_col_end) &&
                    !(END_WIDTH'(pend_col_start) > in_col_end);
  assign row_fits = (pend_col_start == item.first_col) &&
                    (pend_col_count == SPAN_WIDTH'(item.col_len)) &&
                    !(END_WIDTH'(item.first_row) > pend_row_end) &&
                    !(END_WIDTH'(pend_row_start) > in_row_end);

  assign seen_inc = (seen_count == SEEN_MAX) ? seen_count : seen_count + 1'b1;

  always_comb begin
    emitted               = '0;
    emitted.has_block     = 1'b1;
    emitted.out_row_start = pend_row_start;
    emitted.out_row_count = pend_row_count;
    emitted.out_col_start = pend_col_start;
    emitted.out_col_count = pend_col_count;
    emitted.out_red       = pend_red;
    emitted.out_green     = pend_green;
    emitted.out_blue      = pend_blue;
  end

  always_comb begin
    result_t final_res;

    pend_valid_next     = pend_valid;
    overflowed_next     = overflowed;
    kept_count_next     = kept_count;
    seen_count_next     = seen_count;
    pend_row_start_next = pend_row_start;
    pend_col_start_next = pend_col_start;
    pend_row_count_next = pend_row_count;
    pend_col_count_next = pend_col_count;
    pend_red_next       = pend_red;
    pend_green_next     = pend_green;
    pend_blue_next      = pend_blue;
    push                = '0;
    final_res           = '0;

    if (item_valid) begin
      if (!overflowed) begin
        seen_count_next = seen_inc;
        priority if (seen_inc > COUNT_WIDTH'(input_limit)) begin
          overflowed_next = 1'b1;
          pend_valid_next = 1'b0;
        end else if (!nonempty) begin
          // Empty rectangles leave the pending one untouched.
          pend_valid_next = pend_valid;
        end else if (color_match && col_fits) begin
          pend_col_start_next = col_lo;
          pend_col_count_next = SPAN_WIDTH'(col_hi - END_WIDTH'(col_lo));
        end else if (color_match && row_fits) begin
          pend_row_start_next = row_lo;
          pend_row_count_next = SPAN_WIDTH'(row_hi - END_WIDTH'(row_lo));
        end else if (kept_count >= COUNT_WIDTH'(block_capacity)) begin
          overflowed_next = 1'b1;
          pend_valid_next = 1'b0;
        end else begin
          push.first_valid    = pend_valid;
          push.first          = emitted;
          pend_row_start_next = item.first_row;
          pend_col_start_next = item.first_col;
          pend_row_count_next = SPAN_WIDTH'(item.row_len);
          pend_col_count_next = SPAN_WIDTH'(item.col_len);
          pend_red_next       = item.red_bits;
          pend_green_next     = item.green_bits;
          pend_blue_next      = item.blue_bits;
          pend_valid_next     = 1'b1;
          kept_count_next     = kept_count + 1'b1;
        end
      end

      if (item.end_of_list) begin
        final_res.final_result = 1'b1;
        final_res.list_status  = overflowed_next;
        if (pend_valid_next && !overflowed_next) begin
          final_res.has_block     = 1'b1;
          final_res.out_row_start = pend_row_start_next;
          final_res.out_row_count = pend_row_count_next;
          final_res.out_col_start = pend_col_start_next;
          final_res.out_col_count = pend_col_count_next;
          final_res.out_red       = pend_red_next;
          final_res.out_green     = pend_green_next;
          final_res.out_blue      = pend_blue_next;
        end
        if (push.first_valid) begin
          push.second_valid = 1'b1;
          push.second       = final_res;
        end else begin
          push.first_valid = 1'b1;
          push.first       = final_res;
        end
        pend_valid_next = 1'b0;
        overflowed_next = 1'b0;
        kept_count_next = '0;
        seen_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      overflowed <= 1'b0;
      kept_count <= '0;
      seen_count <= '0;
    end else begin
      pend_valid <= pend_valid_next;
      overflowed <= overflowed_next;
      kept_count <= kept_count_next;
      seen_count <= seen_count_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_row_start <= pend_row_start_next;
    pend_col_start <= pend_col_start_next;
    pend_row_count <= pend_row_count_next;
    pend_col_count <= pend_col_count_next;
    pend_red       <= pend_red_next;
    pend_green     <= pend_green_next;
    pend_blue      <= pend_blue_next;
  end

endmodule

`default_nettype wire

// ----- design/scbc_port_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module scbc_port_checker import scbc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  logic block_empty;
  logic block_sized;
  logic result_stall;
  logic status_shown;

  assign block_empty = (result.out_row_start == '0) && (result.out_row_count == '0) &&
                       (result.out_col_start == '0) && (result.out_col_count == '0) &&
                       (result.out_red == '0) && (result.out_green == '0) &&
                       (result.out_blue == '0);
  assign block_sized  = (result.out_row_count != '0) && (result.out_col_count != '0);
  assign result_stall = result_valid && !result_ready;
  assign status_shown = result_valid && result.list_status;

  // A waiting result holds until its transfer.
  `ASSERT_CLK_DIS(a_result_holds, clk, rst, result_stall |=> result_valid && $stable(result))

  // No result is valid just after reset; one appears only once a rectangle has been taken.
  `ASSERT_CLK(a_reset_quiet, clk, rst |=> !result_valid)

  // Overflow is reported only on the final result of a list.
  `ASSERT_CLK_DIS(a_status_on_final, clk, rst, status_shown |-> result.final_result)

  // A result without a block carries all-zero rectangle and color fields.
  `ASSERT_CLK_DIS(a_no_block_zero, clk, rst, result_valid && !result.has_block |-> block_empty)

  // Every emitted block is nonempty, since empty inputs are dropped.
  `ASSERT_CLK_DIS(a_block_nonempty, clk, rst, result_valid && result.has_block |-> block_sized)

endmodule

bind same_color_block_coalescer_unit scbc_port_checker u_port_checker (.*);

`default_nettype wire
